### hdl/bfm_pkg.sv
// Shared types and constants for the buffer frame manager.
// No dependencies.
package bfm_pkg;
  localparam int NumFrames = 16;
  localparam int FrameW = $clog2(NumFrames);
  localparam int PageW = 20;
  localparam int StampW = 32;

  typedef enum logic [1:0] {
    OP_PIN = 2'd0, OP_UNPIN = 2'd1, OP_FREE = 2'd2, OP_FLUSH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_MISSING = 3'd2, ST_UNPINNED = 3'd3,
    ST_PINNED = 3'd4
  } status_e;

  typedef struct packed {
    logic [FrameW:0] unpinned_count;
    logic release_request;
    logic [PageW-1:0] write_page_id;
    logic write_request;
    logic read_request;
    logic [FrameW-1:0] frame_index;
    logic [2:0] status;
  } result_t;
endpackage

### hdl/bfm_stamp_ram.sv
// Synchronous memory of unpin stamps, one entry per frame.
// Depends on bfm_pkg.
module bfm_stamp_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [bfm_pkg::FrameW-1:0] waddr_i,
  input  logic [bfm_pkg::StampW-1:0] wdata_i,
  input  logic [bfm_pkg::FrameW-1:0] raddr_i,
  output logic [bfm_pkg::StampW-1:0] rdata_o
);
  import bfm_pkg::*;
  logic [StampW-1:0] mem [NumFrames];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

### hdl/buffer_frame_manager_love_hate.sv
// Top level of the buffer frame manager: frame table, lookup and victim scan.
// Depends on bfm_pkg and bfm_stamp_ram.
//
// channel | dir | fields
// s_axis  | in  | tdata: opcode, page_id, empty_page, dirty_flag, hate_flag
// m_axis  | out | tdata: status, frame_index, read_request, write_request,
//         |     |        write_page_id, release_request, unpinned_count
//
// A request passes through S_IDLE, S_LOOK, S_DONE and S_OUT when no victim is needed; a pin
// that evicts also walks the stamp memory in S_SCAN, one frame per cycle.
// Reset empties every frame and clears the stamp counter.
// The result waits in the output register; a new request is taken when it
// has been delivered.
module buffer_frame_manager_love_hate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], page_id[21:2], empty_page[22], dirty_flag[23], hate_flag[24]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], frame_index[6:3], read_request[7], write_request[8],
  // write_page_id[28:9], release_request[29], unpinned_count[34:30]
  output logic [39:0] m_axis_tdata
);
  import bfm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SCAN, S_DONE, S_OUT} state_e;

  state_e state_q;
  logic [1:0] op_q;
  logic [PageW-1:0] pg_q;
  logic empty_q, dirty_q, hate_q;
  logic [NumFrames-1:0] valid_q, hated_q;
  logic [PageW-1:0] page_q [NumFrames];
  logic [7:0] pin_q [NumFrames];
  logic [StampW-1:0] ctr_q;
  logic hit_q, hasempty_q;
  logic [FrameW-1:0] hitf_q, emptyf_q;
  logic [FrameW:0] scan_q;
  logic hv_q, lv_q;
  logic [FrameW-1:0] hf_q, lf_q;
  logic [StampW-1:0] hage_q, lage_q;
  result_t res_q;

  logic ram_we;
  logic [FrameW-1:0] ram_waddr, ram_raddr;
  logic [StampW-1:0] ram_rdata;

  bfm_stamp_ram u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ctr_q),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {5'd0, res_q};
  assign ram_raddr = scan_q[FrameW-1:0];
  assign ram_waddr = hitf_q;
  assign ram_we = (state_q == S_DONE) && op_q == OP_UNPIN && hit_q &&
                  pin_q[hitf_q] == 8'd1;

  logic hit_c, emp_c;
  logic [FrameW-1:0] hitf_c, empf_c;
  always_comb begin
    hit_c = 1'b0; emp_c = 1'b0; hitf_c = '0; empf_c = '0;
    for (int i = NumFrames - 1; i >= 0; i--) begin
      if (valid_q[i] && page_q[i] == pg_q) begin
        hit_c = 1'b1; hitf_c = FrameW'(i);
      end
      if (!valid_q[i]) begin
        emp_c = 1'b1; empf_c = FrameW'(i);
      end
    end
  end

  // Unpinned count before the update in S_DONE; computed from registers.
  logic [FrameW:0] cnt_c;
  always_comb begin
    cnt_c = '0;
    for (int i = 0; i < NumFrames; i++)
      if (pin_q[i] == 8'd0) cnt_c = cnt_c + (FrameW+1)'(1);
  end

  // Scan element from previous cycle's read.
  logic [FrameW-1:0] sidx;
  logic [StampW-1:0] age_c;
  assign sidx = scan_q[FrameW-1:0] - FrameW'(1);
  assign age_c = ctr_q - ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    result_t res_d;
    logic [FrameW-1:0] e;
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      hated_q <= '0;
      ctr_q <= '0;
      for (int i = 0; i < NumFrames; i++) pin_q[i] <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          op_q <= s_axis_tdata[1:0];
          pg_q <= s_axis_tdata[21:2];
          empty_q <= s_axis_tdata[22];
          dirty_q <= s_axis_tdata[23];
          hate_q <= s_axis_tdata[24];
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          hit_q <= hit_c; hitf_q <= hitf_c;
          hasempty_q <= emp_c; emptyf_q <= empf_c;
          scan_q <= '0; hv_q <= 1'b0; lv_q <= 1'b0;
          state_q <= (op_q == OP_PIN && !hit_c && !emp_c) ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          if (scan_q != '0 && valid_q[sidx] && pin_q[sidx] == 8'd0) begin
            if (hated_q[sidx]) begin
              if (!hv_q || age_c < hage_q) begin
                hv_q <= 1'b1; hf_q <= sidx; hage_q <= age_c;
              end
            end else if (!lv_q || age_c > lage_q) begin
              lv_q <= 1'b1; lf_q <= sidx; lage_q <= age_c;
            end
          end
          if (scan_q == (FrameW+1)'(NumFrames)) state_q <= S_DONE;
          scan_q <= scan_q + (FrameW+1)'(1);
        end
        S_DONE: begin
          res_d = '0;
          state_q <= S_OUT;
          case (op_q)
            OP_PIN: begin
              if (hit_q) begin
                if (pin_q[hitf_q] != 8'hFF) pin_q[hitf_q] <= pin_q[hitf_q] + 8'd1;
                res_d.frame_index = hitf_q;
                res_d.unpinned_count = cnt_c - (FrameW+1)'(pin_q[hitf_q] == 8'd0);
              end else if (hasempty_q || hv_q || lv_q) begin
                e = hasempty_q ? emptyf_q : (hv_q ? hf_q : lf_q);
                valid_q[e] <= 1'b1; page_q[e] <= pg_q; pin_q[e] <= 8'd1;
                hated_q[e] <= 1'b0;
                res_d.frame_index = e;
                res_d.read_request = !empty_q;
                res_d.write_request = !hasempty_q;
                res_d.write_page_id = hasempty_q ? '0 : page_q[e];
                res_d.unpinned_count = cnt_c - (FrameW+1)'(1);
              end else begin
                res_d.status = ST_FULL;
                res_d.unpinned_count = cnt_c;
              end
            end
            OP_UNPIN: begin
              res_d.unpinned_count = cnt_c;
              if (!hit_q) res_d.status = ST_MISSING;
              else if (pin_q[hitf_q] == 8'd0) res_d.status = ST_UNPINNED;
              else begin
                pin_q[hitf_q] <= pin_q[hitf_q] - 8'd1;
                res_d.frame_index = hitf_q;
                if (pin_q[hitf_q] == 8'd1) begin
                  ctr_q <= ctr_q + StampW'(1);
                  hated_q[hitf_q] <= hate_q;
                  res_d.write_request = dirty_q;
                  res_d.write_page_id = dirty_q ? pg_q : '0;
                  res_d.unpinned_count = cnt_c + (FrameW+1)'(1);
                end
              end
            end
            OP_FREE: begin
              res_d.unpinned_count = cnt_c;
              if (hit_q) begin
                if (pin_q[hitf_q] != 8'd0) res_d.status = ST_PINNED;
                else begin
                  valid_q[hitf_q] <= 1'b0; hated_q[hitf_q] <= 1'b0;
                  res_d.release_request = 1'b1;
                  res_d.frame_index = hitf_q;
                end
              end
            end
            default: begin
              res_d.unpinned_count = cnt_c;
              if (!hit_q) res_d.status = ST_MISSING;
              else begin
                res_d.write_request = 1'b1;
                res_d.write_page_id = pg_q;
                res_d.frame_index = hitf_q;
              end
            end
          endcase
          res_q <= res_d;
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/bfm_checker.sv
// Port-level checks for the buffer frame manager, bound to the top level.
// Depends on bfm_pkg and buffer_frame_manager_love_hate.
module bfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import bfm_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("request taken while result waits");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_PINNED) else $error("bad status");
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[2:0] == ST_OK)
    else $error("read on error");
endmodule

bind buffer_frame_manager_love_hate bfm_checker u_bfm_checker (.*);

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the buffer frame manager: directed rows, then random
// pin/unpin/free/flush traffic under several idling phases. Depends on bfm_pkg.
module tb;
  import bfm_pkg::*;

  typedef struct packed {
    logic [4:0] unpinned_count;
    logic release_request;
    logic [19:0] write_page_id;
    logic write_request;
    logic read_request;
    logic [3:0] frame_index;
    logic [2:0] status;
  } answer_t;

  typedef struct {
    op_e op;
    logic [19:0] page;
    logic empty_pg;
    logic dirty;
    logic hate;
    logic known;
    answer_t ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  logic f_valid [NumFrames];
  logic [19:0] f_page [NumFrames];
  logic [7:0] f_pins [NumFrames];
  logic f_hated [NumFrames];
  logic [31:0] f_stamp [NumFrames];
  logic [31:0] stamp_now;

  answer_t pending_answers[$];
  int fail_count = 0;
  int request_count = 0;
  int answer_count = 0;
  int evict_count = 0;
  int full_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;
  logic [19:0] page_pool [8];

  buffer_frame_manager_love_hate DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int lookup_frame(logic [19:0] pg);
    for (int i = 0; i < NumFrames; i++)
      if (f_valid[i] && f_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic int choose_victim();
    int hv, lv;
    logic [31:0] hage, lage, age;
    hv = -1;
    lv = -1;
    hage = 0;
    lage = 0;
    for (int i = 0; i < NumFrames; i++) begin
      if (!f_valid[i] || f_pins[i] != 0) continue;
      age = stamp_now - f_stamp[i];
      if (f_hated[i]) begin
        if (hv < 0 || age < hage) begin
          hv = i;
          hage = age;
        end
      end else if (lv < 0 || age > lage) begin
        lv = i;
        lage = age;
      end
    end
    return (hv >= 0) ? hv : lv;
  endfunction

  // Applies one request to the frame table copy and returns the expected answer.
  function automatic answer_t frame_table_step(op_e op, logic [19:0] pg, logic empty_pg,
                                               logic dirty, logic hate);
    answer_t a;
    int f, e, n;
    a = '0;
    f = lookup_frame(pg);
    case (op)
      OP_PIN: begin
        if (f >= 0) begin
          if (f_pins[f] < 255) f_pins[f]++;
          a.frame_index = 4'(f);
        end else begin
          e = -1;
          for (int i = 0; i < NumFrames; i++)
            if (!f_valid[i] && e < 0) e = i;
          if (e < 0) begin
            e = choose_victim();
            if (e >= 0) begin
              a.write_request = 1'b1;
              a.write_page_id = f_page[e];
              evict_count++;
            end
          end
          if (e < 0) begin
            a.status = ST_FULL;
            full_count++;
          end else begin
            f_valid[e] = 1'b1;
            f_page[e] = pg;
            f_pins[e] = 8'd1;
            f_hated[e] = 1'b0;
            a.read_request = !empty_pg;
            a.frame_index = 4'(e);
          end
        end
      end
      OP_UNPIN: begin
        if (f < 0) a.status = ST_MISSING;
        else if (f_pins[f] == 0) a.status = ST_UNPINNED;
        else begin
          f_pins[f]--;
          if (f_pins[f] == 0) begin
            f_stamp[f] = stamp_now;
            stamp_now++;
            f_hated[f] = hate;
            if (dirty) begin
              a.write_request = 1'b1;
              a.write_page_id = pg;
            end
          end
          a.frame_index = 4'(f);
        end
      end
      OP_FREE: begin
        if (f >= 0) begin
          if (f_pins[f] != 0) a.status = ST_PINNED;
          else begin
            f_valid[f] = 1'b0;
            f_pins[f] = 8'd0;
            f_hated[f] = 1'b0;
            a.release_request = 1'b1;
            a.frame_index = 4'(f);
          end
        end
      end
      default: begin
        if (f < 0) a.status = ST_MISSING;
        else begin
          a.write_request = 1'b1;
          a.write_page_id = pg;
          a.frame_index = 4'(f);
        end
      end
    endcase
    n = 0;
    for (int i = 0; i < NumFrames; i++)
      if (f_pins[i] == 0) n++;
    a.unpinned_count = 5'(n);
    return a;
  endfunction

  task automatic send_request(op_e op, logic [19:0] pg, logic empty_pg, logic dirty,
                              logic hate, logic known, answer_t typed);
    answer_t a;
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    a = frame_table_step(op, pg, empty_pg, dirty, hate);
    if (known && a !== typed) begin
      $display("%0t: directed row disagrees with predictor: typed %h predicted %h",
               $time, typed, a);
      fail_count++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, hate, dirty, empty_pg, pg, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_answers.push_back(a);
    request_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (NumFrames + 8) @(posedge clk_i);
  endtask

  function automatic logic [19:0] pick_page();
    if ($urandom_range(9, 0) == 0) return 20'($urandom());
    return page_pool[$urandom_range(7, 0)];
  endfunction

  task automatic random_burst(int count);
    op_e op;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99, 0);
      op = (r < 45) ? OP_PIN : (r < 85) ? OP_UNPIN : (r < 93) ? OP_FREE : OP_FLUSH;
      send_request(op, pick_page(), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                   1'($urandom_range(1, 0)), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || long_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[34:0];
      answer_count++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer %h", $time, got);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status || got.frame_index !== want.frame_index ||
            got.read_request !== want.read_request ||
            got.write_request !== want.write_request ||
            got.write_page_id !== want.write_page_id ||
            got.release_request !== want.release_request ||
            got.unpinned_count !== want.unpinned_count || m_axis_tdata[39:35] !== 5'd0) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic answer_t typed_answer(logic [2:0] st, int fi, int rd, int wr,
                                           int wp, int rel, int cnt);
    answer_t a;
    a = {5'(cnt), 1'(rel), 20'(wp), 1'(wr), 1'(rd), 4'(fi), st};
    return a;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    for (int i = 0; i < NumFrames; i++) begin
      f_valid[i] = 1'b0;
      f_page[i] = '0;
      f_pins[i] = '0;
      f_hated[i] = 1'b0;
      f_stamp[i] = '0;
    end
    stamp_now = '0;
    for (int i = 0; i < 8; i++) page_pool[i] = 20'($urandom());
    page_pool[0] = 20'hFFFFF;
    page_pool[1] = 20'h00000;

    rows.push_back('{OP_UNPIN, 20'h12345, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_MISSING, 0, 0, 0, 0, 0, 16)});
    rows.push_back('{OP_FLUSH, 20'h12345, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_MISSING, 0, 0, 0, 0, 0, 16)});
    rows.push_back('{OP_FREE, 20'h12345, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_OK, 0, 0, 0, 0, 0, 16)});
    rows.push_back('{OP_PIN, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_OK, 0, 1, 0, 0, 0, 15)});
    rows.push_back('{OP_PIN, 20'h00000, 1'b1, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_OK, 1, 0, 0, 0, 0, 14)});
    rows.push_back('{OP_PIN, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_OK, 0, 0, 0, 0, 0, 14)});
    rows.push_back('{OP_FREE, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_PINNED, 0, 0, 0, 0, 0, 14)});
    rows.push_back('{OP_FLUSH, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_OK, 0, 0, 1, 20'hFFFFF, 0, 14)});
    rows.push_back('{OP_UNPIN, 20'hFFFFF, 1'b0, 1'b1, 1'b1, 1'b1,
                     typed_answer(ST_OK, 0, 0, 0, 0, 0, 14)});
    rows.push_back('{OP_UNPIN, 20'hFFFFF, 1'b0, 1'b1, 1'b1, 1'b1,
                     typed_answer(ST_OK, 0, 0, 1, 20'hFFFFF, 0, 15)});
    rows.push_back('{OP_UNPIN, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_UNPINNED, 0, 0, 0, 0, 0, 15)});
    rows.push_back('{OP_FREE, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_OK, 0, 0, 0, 0, 1, 15)});
    for (int i = 0; i < 15; i++) begin
      r = '{OP_PIN, 20'(i + 16), i[0], 1'b0, 1'b0, 1'b0, '0};
      rows.push_back(r);
    end
    rows.push_back('{OP_PIN, 20'hABCDE, 1'b0, 1'b0, 1'b0, 1'b1,
                     typed_answer(ST_FULL, 0, 0, 0, 0, 0, 0)});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_request(rows[i].op, rows[i].page, rows[i].empty_pg, rows[i].dirty,
                   rows[i].hate, rows[i].known, rows[i].ans);
    // Unpin a mix of hated and loved frames, then force evictions.
    for (int i = 0; i < 15; i++)
      send_request(OP_UNPIN, 20'(i + 16), 1'b0, i[1], i[0], 1'b0, '0);
    for (int i = 0; i < 6; i++)
      send_request(OP_PIN, 20'(i + 100), 1'b0, 1'b0, 1'b0, 1'b0, '0);
    drain();

    random_burst(200);
    idle_pct = 57;
    random_burst(150);
    drain();
    idle_pct = 0;
    stall_pct = 57;
    random_burst(150);
    idle_pct = 32;
    stall_pct = 32;
    random_burst(150);
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      random_burst(100);
    join
    drain();

    $display("Sent %0d requests, checked %0d answers, %0d evictions, %0d pool-full.",
             request_count, answer_count, evict_count, full_count);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
hdl/bfm_pkg.sv
hdl/bfm_stamp_ram.sv
hdl/buffer_frame_manager_love_hate.sv
hdl/bfm_checker.sv
dv/tb.sv
